// ===== hw/rtl/ljpf_pkg.sv =====
// Shared constants for the Lennard-Jones pair force pipeline.
// Used by ljpf_mul and lennard_jones_pair_force; depends on nothing.

package ljpf_pkg;

   // Width of every magnitude on the multiply chain: values up to 2^62.
   localparam int MUL_W = 63;

   // Overflow marker: a clamped product, exactly 2^62.
   localparam logic [MUL_W-1:0] OVF_VAL = {1'b1, {(MUL_W-1){1'b0}}};

endpackage

// ===== hw/rtl/ljpf_mul.sv =====
// Three-stage fixed-point multiplier floor(a*b / 2^SHIFT) with overflow marker.
// Depends on ljpf_pkg for the operand width and the overflow value.

module ljpf_mul #(
   parameter int SHIFT = 32
) (
   input  logic                         clock,
   input  logic [ljpf_pkg::MUL_W-1:0]   mul_a,
   input  logic [ljpf_pkg::MUL_W-1:0]   mul_b,
   output logic [ljpf_pkg::MUL_W-1:0]   mul_p
);

   localparam int MW = ljpf_pkg::MUL_W;
   localparam int PW = 2 * MW;

   logic [63:0]    p00_in, p01_in, p10_in;
   logic [61:0]    p11_in;
   logic [63:0]    p00_ff, p01_ff, p10_ff;
   logic [61:0]    p11_ff;
   logic [1:0]     zero_ff, ovf_ff;
   logic [PW-1:0]  prod_in, prod_ff;
   logic [PW-1:0]  shifted;
   logic [MW-1:0]  mul_p_in, mul_p_ff;

   // partial products of the low 32-bit and high 31-bit parts
   assign p00_in = 64'(mul_a[31:0])    * 64'(mul_b[31:0]);
   assign p01_in = 64'(mul_a[31:0])    * 64'(mul_b[MW-1:32]);
   assign p10_in = 64'(mul_a[MW-1:32]) * 64'(mul_b[31:0]);
   assign p11_in = 62'(mul_a[MW-1:32]) * 62'(mul_b[MW-1:32]);

   assign prod_in = {62'b0, p00_ff} + {30'b0, p01_ff, 32'b0} + {30'b0, p10_ff, 32'b0}
                  + {p11_ff, 64'b0};

   assign shifted = prod_ff >> SHIFT;

   always_comb begin
      if (zero_ff[1]) begin
         mul_p_in = '0;
      end else if (ovf_ff[1] || (|shifted[PW-1:MW-1])) begin
         mul_p_in = ljpf_pkg::OVF_VAL;
      end else begin
         mul_p_in = shifted[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      p00_ff     <= p00_in;
      p01_ff     <= p01_in;
      p10_ff     <= p10_in;
      p11_ff     <= p11_in;
      zero_ff[0] <= (mul_a == '0) || (mul_b == '0);
      ovf_ff[0]  <= (mul_a >= ljpf_pkg::OVF_VAL) || (mul_b >= ljpf_pkg::OVF_VAL);
      zero_ff[1] <= zero_ff[0];
      ovf_ff[1]  <= ovf_ff[0];
      prod_ff    <= prod_in;
      mul_p_ff   <= mul_p_in;
   end

   assign mul_p = mul_p_ff;

endmodule

// ===== hw/rtl/lennard_jones_pair_force.sv =====
// Lennard-Jones 12-6 pair force with minimum-image folding, fully pipelined.
// Depends on ljpf_pkg and ljpf_mul.

// One request enters per clock whenever start is high; busy never rises, so the
// block accepts a new request in every cycle. Each request produces one result,
// shown on the rsp_ ports for a single cycle under rsp_strobe, and it is valid
// only while rsp_strobe is high; the receiver must take it then. The pipeline
// holds the bit-per-stage remainder unit that folds the coordinate difference
// into the box (34 stages), the bit-per-stage reciprocal of r^2 (49 stages)
// and the chain of pipelined multipliers that forms the powers of 1/r.
// Registers are written through csr_ at any edge with csr_write_enable high, but
// must only change when no request is in flight. A box size of zero acts as 1.

module lennard_jones_pair_force (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic               rsp_strobe,
   output logic signed [47:0] rsp_force_x,
   output logic signed [47:0] rsp_force_y,
   output logic signed [47:0] rsp_force_z,
   output logic signed [47:0] rsp_pair_energy,
   output logic               rsp_in_range,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [39:0]        csr_write_data
);

   localparam int MW          = ljpf_pkg::MUL_W;
   localparam int FOLD_STEPS  = 34;
   localparam int RECIP_STEPS = 49;
   localparam int MUL_LAT     = 3;
   // pipeline layers, counted in registers after the accepting edge
   localparam int LAYER_F     = FOLD_STEPS + 4;
   localparam int CARRY_INJ   = 3;
   localparam int LAYER_U     = LAYER_F + CARRY_INJ + RECIP_STEPS + 1;
   localparam int LAYER_OUT   = LAYER_U + 5 * MUL_LAT + 2;
   localparam int CARRY_LEN   = LAYER_OUT - 1 - LAYER_F;
   localparam int CARRY_ABS   = LAYER_U + 4 * MUL_LAT + 1 - LAYER_F;
   localparam int DNEG_DLY    = 2 * MUL_LAT;
   localparam int REP_DLY     = MUL_LAT + 1;
   localparam int ATT_DLY     = 2 * MUL_LAT + 1;

   localparam logic [1:0] CSR_BOX_SIZE  = 2'd0;
   localparam logic [1:0] CSR_CUTOFF_SQ = 2'd1;
   localparam logic [1:0] CSR_REP_COEFF = 2'd2;
   localparam logic [1:0] CSR_ATT_COEFF = 2'd3;

   localparam logic [30:0]   BOX_RESET   = 31'd65536;
   localparam logic [MW-1:0] FORCE_SCALE = 63'd6;
   localparam logic [MW-1:0] NEG_LIM     = 63'h0000_8000_0000_0000;
   localparam logic [MW-1:0] POS_LIM     = 63'h0000_7FFF_FFFF_FFFF;

   // per-request side data that rides along the pipeline from the fold to the result
   typedef struct packed {
      logic             inr;
      logic             zero;
      logic [2:0]       fneg;
      logic [2:0][30:0] absf;
   } carry_type;

   // clamp a sign and magnitude to 48 signed bits; top bit flags a clamp
   function automatic logic [48:0] clamp48(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] m;
      logic          sat;
      logic [47:0]   v;
      m   = mag;
      sat = 1'b0;
      if (neg) begin
         if (mag > NEG_LIM) begin
            m   = NEG_LIM;
            sat = 1'b1;
         end
         v = 48'd0 - m[47:0];
      end else begin
         if (mag > POS_LIM) begin
            m   = POS_LIM;
            sat = 1'b1;
         end
         v = m[47:0];
      end
      return {sat, v};
   endfunction

   // ---------------------------------------------------------------- registers
   logic [30:0] box_size_ff;
   logic [39:0] cutoff_sq_ff, rep_coeff_ff, att_coeff_ff;
   logic [30:0] box_eff;
   logic [31:0] den;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_size_ff  <= BOX_RESET;
         cutoff_sq_ff <= '0;
         rep_coeff_ff <= '0;
         att_coeff_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BOX_SIZE:  box_size_ff  <= csr_write_data[30:0];
            CSR_CUTOFF_SQ: cutoff_sq_ff <= csr_write_data;
            CSR_REP_COEFF: rep_coeff_ff <= csr_write_data;
            CSR_ATT_COEFF: att_coeff_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // zero box behaves as the smallest box; the fold divides by twice the box
   assign box_eff = (box_size_ff == '0) ? 31'd1 : box_size_ff;
   assign den     = {box_eff, 1'b0};

   // ---------------------------------------------------------------- valid line
   logic valid_ff [0:LAYER_OUT];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAYER_OUT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= start && !busy;
         for (int i = 1; i <= LAYER_OUT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- difference
   logic signed [31:0] first_c  [3];
   logic signed [31:0] second_c [3];
   logic signed [32:0] d_in [3];
   logic signed [32:0] d_ff [3];

   assign first_c[0]  = req_first_x;
   assign first_c[1]  = req_first_y;
   assign first_c[2]  = req_first_z;
   assign second_c[0] = req_second_x;
   assign second_c[1] = req_second_y;
   assign second_c[2] = req_second_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_in[a] = 33'(first_c[a]) - 33'(second_c[a]);
      end
   end

   // ---------------------------------------------------------------- fold
   // Floor remainder of (2d + box) by 2*box, one dividend bit per stage.
   logic [31:0] fd_rem_in [0:FOLD_STEPS][3];
   logic [33:0] fd_mag_in [0:FOLD_STEPS][3];
   logic        fd_neg_in [0:FOLD_STEPS][3];
   logic [31:0] fd_rem_ff [0:FOLD_STEPS][3];
   logic [33:0] fd_mag_ff [0:FOLD_STEPS][3];
   logic        fd_neg_ff [0:FOLD_STEPS][3];

   always_comb begin
      logic signed [34:0] num;
      logic [32:0]        trial;
      for (int a = 0; a < 3; a++) begin
         num = $signed({d_ff[a][32], d_ff[a], 1'b0}) + $signed({4'b0, box_eff});
         fd_rem_in[0][a] = '0;
         fd_neg_in[0][a] = num[34];
         fd_mag_in[0][a] = num[34] ? 34'(-num) : num[33:0];
      end
      for (int k = 1; k <= FOLD_STEPS; k++) begin
         for (int a = 0; a < 3; a++) begin
            trial = {fd_rem_ff[k-1][a], fd_mag_ff[k-1][a][33]};
            if (trial >= {1'b0, den}) begin
               fd_rem_in[k][a] = 32'(trial - {1'b0, den});
            end else begin
               fd_rem_in[k][a] = trial[31:0];
            end
            fd_mag_in[k][a] = {fd_mag_ff[k-1][a][32:0], 1'b0};
            fd_neg_in[k][a] = fd_neg_ff[k-1][a];
         end
      end
   end

   // turn the magnitude remainder into a floor remainder, then recenter
   logic [31:0]        rfix_in [3];
   logic [31:0]        rfix_ff [3];
   logic signed [31:0] folded_in [3];
   logic signed [31:0] folded_ff [3];
   carry_type          carry_in;
   carry_type          carry_ff [0:CARRY_LEN];

   always_comb begin
      logic [31:0] r;
      logic [32:0] diff;
      carry_in = '0;
      for (int a = 0; a < 3; a++) begin
         r = fd_rem_ff[FOLD_STEPS][a];
         rfix_in[a] = (fd_neg_ff[FOLD_STEPS][a] && (r != '0)) ? den - r : r;
         diff = {1'b0, rfix_ff[a]} - {2'b0, box_eff};
         folded_in[a] = diff[32:1];
         carry_in.fneg[a] = folded_ff[a][31];
         carry_in.absf[a] = folded_ff[a][31] ? 31'(-folded_ff[a]) : folded_ff[a][30:0];
      end
   end

   // ---------------------------------------------------------------- distance
   logic [61:0] sq_in [3];
   logic [61:0] sq_ff [3];
   logic [61:0] q_in, q_ff;
   carry_type   carry_inj;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = 62'(carry_ff[0].absf[a]) * 62'(carry_ff[0].absf[a]);
      end
   end

   assign q_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   // range test and zero distance join the side data alongside the divider input
   always_comb begin
      carry_inj      = carry_ff[CARRY_INJ-1];
      carry_inj.inr  = q_ff <= {6'b0, cutoff_sq_ff, 16'b0};
      carry_inj.zero = (q_ff[61:16] == '0);
   end

   // ---------------------------------------------------------------- 1/r^2
   // floor(2^48 / s), one quotient bit per stage
   logic [45:0] rd_rem_in  [0:RECIP_STEPS];
   logic [48:0] rd_quot_in [0:RECIP_STEPS];
   logic [45:0] rd_s_in    [0:RECIP_STEPS];
   logic [45:0] rd_rem_ff  [0:RECIP_STEPS];
   logic [48:0] rd_quot_ff [0:RECIP_STEPS];
   logic [45:0] rd_s_ff    [0:RECIP_STEPS];

   always_comb begin
      logic [46:0] trial;
      rd_rem_in[0]  = '0;
      rd_quot_in[0] = '0;
      rd_s_in[0]    = q_ff[61:16];
      for (int k = 1; k <= RECIP_STEPS; k++) begin
         trial = {rd_rem_ff[k-1], (k == 1)};
         if (trial >= {1'b0, rd_s_ff[k-1]}) begin
            rd_rem_in[k]  = 46'(trial - {1'b0, rd_s_ff[k-1]});
            rd_quot_in[k] = {rd_quot_ff[k-1][47:0], 1'b1};
         end else begin
            rd_rem_in[k]  = trial[45:0];
            rd_quot_in[k] = {rd_quot_ff[k-1][47:0], 1'b0};
         end
         rd_s_in[k] = rd_s_ff[k-1];
      end
   end

   logic [MW-1:0] u2_in, u2_ff;
   logic [MW-1:0] u2_dly_ff [0:MUL_LAT-1];

   // zero distance: treat 1/r^2 as overflow
   assign u2_in = (rd_s_ff[RECIP_STEPS] == '0) ? ljpf_pkg::OVF_VAL
                                               : {14'b0, rd_quot_ff[RECIP_STEPS]};

   // ---------------------------------------------------------------- powers
   logic [MW-1:0] u4, u6, u8, u12, att, pterm, m6, rep, kmag;
   logic [MW-1:0] force_p [3];

   ljpf_mul #(.SHIFT(32)) u_u4   (.clock(clock), .mul_a(u2_ff), .mul_b(u2_ff), .mul_p(u4));
   ljpf_mul #(.SHIFT(32)) u_u6   (.clock(clock), .mul_a(u4), .mul_b(u2_dly_ff[MUL_LAT-1]),
                                  .mul_p(u6));
   ljpf_mul #(.SHIFT(32)) u_u8   (.clock(clock), .mul_a(u4), .mul_b(u4), .mul_p(u8));
   ljpf_mul #(.SHIFT(32)) u_u12  (.clock(clock), .mul_a(u6), .mul_b(u6), .mul_p(u12));
   ljpf_mul #(.SHIFT(32)) u_att  (.clock(clock), .mul_a({23'b0, att_coeff_ff}), .mul_b(u6),
                                  .mul_p(att));
   ljpf_mul #(.SHIFT(32)) u_pterm (.clock(clock), .mul_a({22'b0, rep_coeff_ff, 1'b0}),
                                   .mul_b(u6), .mul_p(pterm));
   ljpf_mul #(.SHIFT(0))  u_m6   (.clock(clock), .mul_a(u8), .mul_b(FORCE_SCALE), .mul_p(m6));
   ljpf_mul #(.SHIFT(32)) u_rep  (.clock(clock), .mul_a({23'b0, rep_coeff_ff}), .mul_b(u12),
                                  .mul_p(rep));

   // B - 2A/r^6 as sign and magnitude; an overflowed 2A term is hugely negative
   logic          dneg_in, dneg_ff;
   logic [MW-1:0] dmag_in, dmag_ff, m6_ff;
   logic          dneg_dly_ff [0:DNEG_DLY-1];
   logic [MW-1:0] rep_dly_ff  [0:REP_DLY-1];
   logic [MW-1:0] att_dly_ff  [0:ATT_DLY-1];

   always_comb begin
      logic signed [63:0] diff;
      diff = $signed({24'b0, att_coeff_ff}) - $signed({1'b0, pterm});
      if (pterm >= ljpf_pkg::OVF_VAL) begin
         dneg_in = 1'b1;
         dmag_in = ljpf_pkg::OVF_VAL;
      end else begin
         dneg_in = diff[63];
         dmag_in = diff[63] ? 63'(-diff) : diff[62:0];
      end
   end

   ljpf_mul #(.SHIFT(32)) u_kmag (.clock(clock), .mul_a(m6_ff), .mul_b(dmag_ff), .mul_p(kmag));

   for (genvar a = 0; a < 3; a++) begin : g_force
      ljpf_mul #(.SHIFT(16)) u_force (
         .clock (clock),
         .mul_a (kmag),
         .mul_b ({32'b0, carry_ff[CARRY_ABS].absf[a]}),
         .mul_p (force_p[a])
      );
   end

   // ---------------------------------------------------------------- result
   logic [47:0] force_in [3];
   logic [47:0] force_ff [3];
   logic [47:0] energy_in, energy_ff;
   logic        in_range_in, in_range_ff;
   logic        sat_in, sat_ff;

   always_comb begin
      logic [48:0]        cl;
      logic [48:0]        ce;
      logic signed [63:0] e;
      logic               fneg;
      logic               sat;
      sat = carry_ff[CARRY_LEN].zero;
      for (int a = 0; a < 3; a++) begin
         fneg = (force_p[a] != '0) && (dneg_dly_ff[DNEG_DLY-1] != carry_ff[CARRY_LEN].fneg[a]);
         cl   = clamp48(fneg, force_p[a]);
         sat  = sat | cl[48];
         force_in[a] = cl[47:0];
      end
      e = $signed({1'b0, rep_dly_ff[REP_DLY-1]}) - $signed({1'b0, att_dly_ff[ATT_DLY-1]});
      if (rep_dly_ff[REP_DLY-1] >= ljpf_pkg::OVF_VAL) begin
         ce = clamp48(1'b0, ljpf_pkg::OVF_VAL);
      end else if (att_dly_ff[ATT_DLY-1] >= ljpf_pkg::OVF_VAL) begin
         ce = clamp48(1'b1, ljpf_pkg::OVF_VAL);
      end else begin
         ce = clamp48(e[63], e[63] ? 63'(-e) : e[62:0]);
      end
      sat = sat | ce[48];
      energy_in   = ce[47:0];
      in_range_in = carry_ff[CARRY_LEN].inr;
      sat_in      = sat;
      // out of range: drop everything to zero
      if (!carry_ff[CARRY_LEN].inr) begin
         for (int a = 0; a < 3; a++) begin
            force_in[a] = '0;
         end
         energy_in = '0;
         sat_in    = 1'b0;
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      fd_rem_ff <= fd_rem_in;
      fd_mag_ff <= fd_mag_in;
      fd_neg_ff <= fd_neg_in;
      rfix_ff   <= rfix_in;
      folded_ff <= folded_in;
      carry_ff[0] <= carry_in;
      for (int i = 1; i <= CARRY_LEN; i++) begin
         carry_ff[i] <= (i == CARRY_INJ) ? carry_inj : carry_ff[i-1];
      end
      sq_ff      <= sq_in;
      q_ff       <= q_in;
      rd_rem_ff  <= rd_rem_in;
      rd_quot_ff <= rd_quot_in;
      rd_s_ff    <= rd_s_in;
      u2_ff      <= u2_in;
      u2_dly_ff[0] <= u2_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         u2_dly_ff[i] <= u2_dly_ff[i-1];
      end
      dneg_ff <= dneg_in;
      dmag_ff <= dmag_in;
      m6_ff   <= m6;
      dneg_dly_ff[0] <= dneg_ff;
      for (int i = 1; i < DNEG_DLY; i++) begin
         dneg_dly_ff[i] <= dneg_dly_ff[i-1];
      end
      rep_dly_ff[0] <= rep;
      for (int i = 1; i < REP_DLY; i++) begin
         rep_dly_ff[i] <= rep_dly_ff[i-1];
      end
      att_dly_ff[0] <= att;
      for (int i = 1; i < ATT_DLY; i++) begin
         att_dly_ff[i] <= att_dly_ff[i-1];
      end
      force_ff    <= force_in;
      energy_ff   <= energy_in;
      in_range_ff <= in_range_in;
      sat_ff      <= sat_in;
   end

   assign rsp_strobe      = valid_ff[LAYER_OUT];
   assign rsp_force_x     = force_ff[0];
   assign rsp_force_y     = force_ff[1];
   assign rsp_force_z     = force_ff[2];
   assign rsp_pair_energy = energy_ff;
   assign rsp_in_range    = in_range_ff;
   assign rsp_saturated   = sat_ff;

   // ---------------------------------------------------------------- assertions
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(LAYER_OUT+1) rsp_strobe)
      else $error("request did not produce a result at the fixed latency");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_in_range |-> rsp_force_x == '0 && rsp_force_y == '0 &&
         rsp_force_z == '0 && rsp_pair_energy == '0 && !rsp_saturated)
      else $error("out-of-range result is not all zero");

   a_zero_distance_sat: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAYER_OUT-1] && carry_ff[CARRY_LEN].inr && carry_ff[CARRY_LEN].zero
         |=> rsp_saturated)
      else $error("zero distance in range did not flag saturation");

endmodule

// ===== bench/lennard_jones_pair_force_tb.sv =====
// Self-checking testbench for the Lennard-Jones pair force pipeline.
// Depends on the lennard_jones_pair_force RTL and its package ljpf_pkg.

module lennard_jones_pair_force_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] PRODUCT_LIMIT = 64'h1 << 62;
   localparam logic [63:0] FORCE_HIGH    = (64'h1 << 47) - 64'h1;
   localparam logic [63:0] FORCE_LOW_MAG = 64'h1 << 47;
   localparam int          PIPE_DRAIN    = 130;
   localparam int          ONE           = 65536;

   typedef enum logic [1:0] {
      REG_BOX_SIZE, REG_CUTOFF_SQUARED, REG_REPULSIVE, REG_ATTRACTIVE
   } csr_reg_type;

   typedef struct {
      logic signed [31:0] first_x, first_y, first_z;
      logic signed [31:0] second_x, second_y, second_z;
   } atom_pair_type;

   typedef struct {
      logic signed [47:0] force_x, force_y, force_z, pair_energy;
      logic               in_range, saturated;
   } pair_force_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [31:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic               rsp_strobe;
   logic signed [47:0] rsp_force_x, rsp_force_y, rsp_force_z, rsp_pair_energy;
   logic               rsp_in_range, rsp_saturated;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [39:0]        csr_write_data = '0;

   // local copy of the block's registers, changed only while it is idle
   logic [30:0] box_edge   = 31'd65536;
   logic [39:0] cutoff_sq  = '0;
   logic [39:0] coeff_rep  = '0;
   logic [39:0] coeff_att  = '0;

   atom_pair_type  pending_pairs[$];
   pair_force_type expected_forces[$];
   int             mismatches = 0;
   int             idle_left  = 0;
   bit             quiet      = 0;

   lennard_jones_pair_force i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor(a*b / 2^k), pinned at the overflow marker
   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int k);
      logic [127:0] prod;
      if (a == 0 || b == 0) return 64'd0;
      if (a >= PRODUCT_LIMIT || b >= PRODUCT_LIMIT) return PRODUCT_LIMIT;
      prod = ({64'd0, a} * {64'd0, b}) >> k;
      return (prod >= {64'd0, PRODUCT_LIMIT}) ? PRODUCT_LIMIT : prod[63:0];
   endfunction

   // clamp a sign/magnitude value to 48 signed bits
   function automatic logic signed [47:0] clamp48(bit neg, logic [63:0] mag, inout bit sat);
      logic [63:0] m;
      m = mag;
      if (neg) begin
         if (m > FORCE_LOW_MAG) begin
            m = FORCE_LOW_MAG;
            sat = 1;
         end
         m = -m;
      end else if (m > FORCE_HIGH) begin
         m = FORCE_HIGH;
         sat = 1;
      end
      return m[47:0];
   endfunction

   function automatic pair_force_type pair_force(atom_pair_type p);
      pair_force_type res;
      longint signed box, d, num, den, n;
      longint signed fold[3], diff, e;
      longint signed first[3], second[3];
      logic [63:0] q, m, s, u2, u4, u6, u8, u12, rep, att, twice, dmag, kmag, fm;
      bit dneg, sat;
      first  = '{longint'(p.first_x), longint'(p.first_y), longint'(p.first_z)};
      second = '{longint'(p.second_x), longint'(p.second_y), longint'(p.second_z)};
      box = (box_edge == 0) ? 1 : longint'({33'd0, box_edge});
      q = 0;
      sat = 0;
      // minimum image: round half up of d/box
      for (int i = 0; i < 3; i++) begin
         d = first[i] - second[i];
         num = 2 * d + box;
         den = 2 * box;
         n = num / den;
         if (num % den != 0 && num < 0) n--;
         fold[i] = d - n * box;
         m = (fold[i] < 0) ? -fold[i] : fold[i];
         q += m * m;   // at most three times 2^60
      end
      res = '{default: '0};
      if (q > ({24'd0, cutoff_sq} << 16)) return res;
      res.in_range = 1;
      s = q >> 16;
      if (s == 0) begin
         u2 = PRODUCT_LIMIT;
         sat = 1;
      end else begin
         u2 = (64'h1 << 48) / s;
      end
      u4    = scaled_product(u2, u2, 32);
      u6    = scaled_product(u4, u2, 32);
      u8    = scaled_product(u4, u4, 32);
      u12   = scaled_product(u6, u6, 32);
      rep   = scaled_product({24'd0, coeff_rep}, u12, 32);
      att   = scaled_product({24'd0, coeff_att}, u6, 32);
      twice = scaled_product({23'd0, coeff_rep, 1'b0}, u6, 32);
      if (twice >= PRODUCT_LIMIT) begin
         dneg = 1;
         dmag = PRODUCT_LIMIT;
      end else begin
         diff = longint'({24'd0, coeff_att}) - longint'(twice);
         dneg = diff < 0;
         dmag = dneg ? -diff : diff;
      end
      kmag = scaled_product(scaled_product(u8, 64'd6, 0), dmag, 32);
      for (int i = 0; i < 3; i++) begin
         m  = (fold[i] < 0) ? -fold[i] : fold[i];
         fm = scaled_product(kmag, m, 16);
         case (i)
            0: res.force_x = clamp48(fm != 0 && (dneg != (fold[i] < 0)), fm, sat);
            1: res.force_y = clamp48(fm != 0 && (dneg != (fold[i] < 0)), fm, sat);
            default: res.force_z = clamp48(fm != 0 && (dneg != (fold[i] < 0)), fm, sat);
         endcase
      end
      if (rep >= PRODUCT_LIMIT) res.pair_energy = clamp48(0, PRODUCT_LIMIT, sat);
      else if (att >= PRODUCT_LIMIT) res.pair_energy = clamp48(1, PRODUCT_LIMIT, sat);
      else begin
         e = longint'(rep) - longint'(att);
         res.pair_energy = clamp48(e < 0, (e < 0) ? -e : e, sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   // Driver: predict on acceptance, then present the next request or idle.
   always @(posedge clock) begin
      pair_force_type predicted;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted       = pair_force(pending_pairs.pop_front());
            expected_forces = {expected_forces, predicted};
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            // open an idle burst that starts with this clock; idle_left counts the rest
            idle_left = $urandom_range(0, 17);
            start <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            start        <= 1'b1;
            req_first_x  <= pending_pairs[0].first_x;
            req_first_y  <= pending_pairs[0].first_y;
            req_first_z  <= pending_pairs[0].first_z;
            req_second_x <= pending_pairs[0].second_x;
            req_second_y <= pending_pairs[0].second_y;
            req_second_z <= pending_pairs[0].second_z;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      pair_force_type exp_res;
      if (!reset && rsp_strobe) begin
         if (expected_forces.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            exp_res = expected_forces.pop_front();
            if (rsp_force_x !== exp_res.force_x) begin
               $error("force_x: expected %0d, got %0d", exp_res.force_x, rsp_force_x);
               mismatches++;
            end
            if (rsp_force_y !== exp_res.force_y) begin
               $error("force_y: expected %0d, got %0d", exp_res.force_y, rsp_force_y);
               mismatches++;
            end
            if (rsp_force_z !== exp_res.force_z) begin
               $error("force_z: expected %0d, got %0d", exp_res.force_z, rsp_force_z);
               mismatches++;
            end
            if (rsp_pair_energy !== exp_res.pair_energy) begin
               $error("pair_energy: expected %0d, got %0d",
                      exp_res.pair_energy, rsp_pair_energy);
               mismatches++;
            end
            if (rsp_in_range !== exp_res.in_range) begin
               $error("in_range: expected %0d, got %0d", exp_res.in_range, rsp_in_range);
               mismatches++;
            end
            if (rsp_saturated !== exp_res.saturated) begin
               $error("saturated: expected %0d, got %0d",
                      exp_res.saturated, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(csr_reg_type idx, logic [39:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         REG_BOX_SIZE:       box_edge  = value[30:0];
         REG_CUTOFF_SQUARED: cutoff_sq = value;
         REG_REPULSIVE:      coeff_rep = value;
         default:            coeff_att = value;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold until every request has come back and the pipe has drained.
   task automatic drain;
      while (pending_pairs.size() != 0 || expected_forces.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic add_pair(int fx, int fy, int fz, int sx, int sy, int sz);
      atom_pair_type pair;
      pair          = '{fx, fy, fz, sx, sy, sz};
      pending_pairs = {pending_pairs, pair};
   endtask

   // Mostly close pairs with random content, some pairs anywhere.
   task automatic add_random_pairs(int count, int spread);
      int fx, fy, fz;
      for (int i = 0; i < count; i++) begin
         fx = $urandom;
         fy = $urandom;
         fz = $urandom;
         if ($urandom_range(0, 4) == 0)
            add_pair(fx, fy, fz, $urandom, $urandom, $urandom);
         else
            add_pair(fx, fy, fz,
                     fx + $signed($urandom_range(0, 2 * spread)) - spread,
                     fy + $signed($urandom_range(0, 2 * spread)) - spread,
                     fz + $signed($urandom_range(0, 2 * spread)) - spread);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: only atoms that coincide after folding fall inside the zero cutoff
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(ONE, 2 * ONE, -ONE, ONE, 2 * ONE, -ONE);
      add_pair(0, 0, 0, ONE / 4, 0, 0);
      add_random_pairs(60, ONE);
      drain();

      // water-like settings: box 20, cutoff 9, A and B of oxygen pairs
      write_reg(REG_BOX_SIZE, 20 * ONE);
      write_reg(REG_CUTOFF_SQUARED, 81 * ONE);
      write_reg(REG_REPULSIVE, 40'd582000 * ONE);
      write_reg(REG_ATTRACTIVE, 40'd595 * ONE);
      add_pair(0, 0, 0, 0, 0, 0);                          // zero distance
      add_pair(0, 0, 0, 1, 0, 0);                          // sub-lsb r^2
      add_pair(0, 0, 0, 3 * ONE, 0, 0);
      add_pair(0, 0, 0, 0, -3 * ONE, 0);
      add_pair(0, 0, 0, 0, 0, 4 * ONE);
      add_pair(0, 0, 0, ONE / 10, 0, 0);                   // repulsive blowup
      add_pair(10 * ONE, 0, 0, 0, 0, 0);                   // exactly half a box
      add_pair(-10 * ONE, 0, 0, 0, 0, 0);
      add_pair(0, 0, 0, 19 * ONE, 0, 0);                   // folds to one unit
      add_pair(0, 0, 0, 9 * ONE, ONE, 0);                  // just out of range
      add_pair(0, 0, 0, 9 * ONE, 0, 0);                    // on the cutoff
      add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h80000000, 32'h80000000);
      add_pair(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000);
      add_pair(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 0, 32'haaaaaaaa, 32'h55555555);
      add_pair(2 * ONE, 3 * ONE, 4 * ONE, -2 * ONE, -ONE, ONE);
      add_random_pairs(300, 6 * ONE);
      drain();

      // every register at its top value
      write_reg(REG_BOX_SIZE, 40'h7fffffff);
      write_reg(REG_CUTOFF_SQUARED, 40'hff_ffff_ffff);
      write_reg(REG_REPULSIVE, 40'hff_ffff_ffff);
      write_reg(REG_ATTRACTIVE, 40'hff_ffff_ffff);
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0);
      add_random_pairs(250, 200 * ONE);
      drain();

      // zero box acts as the smallest box, and A stays zero
      write_reg(REG_BOX_SIZE, 40'd0);
      write_reg(REG_REPULSIVE, 40'd0);
      write_reg(REG_ATTRACTIVE, 40'd3 * ONE);
      add_random_pairs(120, ONE);
      drain();

      // random settings; the last stretch runs without idle gaps
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(REG_BOX_SIZE, $urandom_range(1, 64 * ONE));
         write_reg(REG_CUTOFF_SQUARED,
                   {8'($urandom_range(0, 255)), 32'($urandom)} >> $urandom_range(0, 20));
         write_reg(REG_REPULSIVE,
                   {8'($urandom_range(0, 255)), 32'($urandom)} >> $urandom_range(0, 30));
         write_reg(REG_ATTRACTIVE,
                   {8'($urandom_range(0, 255)), 32'($urandom)} >> $urandom_range(0, 30));
         if (phase == 5) quiet = 1;
         add_random_pairs(100, $urandom_range(ONE / 4, 32 * ONE));
         drain();
      end

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== lennard_jones_pair_force.f =====
hw/rtl/ljpf_pkg.sv
hw/rtl/ljpf_mul.sv
hw/rtl/lennard_jones_pair_force.sv
bench/lennard_jones_pair_force_tb.sv
